[hdl/bcrt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register map, keys and prescaler tables for the bus controller
// register file with its refresh timer. No dependencies.
package bcrt_pkg;

    // Item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register word addresses
    localparam logic [8:0] ADDR_BCR   = 9'h1a0;
    localparam logic [8:0] ADDR_WCR1  = 9'h1a2;
    localparam logic [8:0] ADDR_WCR2  = 9'h1a4;
    localparam logic [8:0] ADDR_WCR3  = 9'h1a6;
    localparam logic [8:0] ADDR_DCR   = 9'h1a8;
    localparam logic [8:0] ADDR_PCR   = 9'h1aa;
    localparam logic [8:0] ADDR_RTCR  = 9'h1ac;
    localparam logic [8:0] ADDR_RTCSR = 9'h1ae;
    localparam logic [8:0] ADDR_RTCNT = 9'h1b0;
    localparam logic [8:0] ADDR_RTCOR = 9'h1b2;

    // Protected range: byte writes here are dropped
    localparam logic [8:0] ADDR_PROT_LO = 9'h1ac;
    localparam logic [8:0] ADDR_PROT_HI = 9'h1b3;

    // Write keys carried in the upper byte
    localparam logic [7:0] KEY_RTCR  = 8'h5a;
    localparam logic [7:0] KEY_RTCSR = 8'ha5;
    localparam logic [7:0] KEY_RTCNT = 8'h69;
    localparam logic [7:0] KEY_RTCOR = 8'h96;

    localparam int PERIOD_W = 21;

    typedef struct packed {
        logic [1:0]  command;
        logic        byte_access;
        logic [8:0]  address;
        logic [15:0] write_data;
    } item_t;

    typedef struct packed {
        logic [15:0] refresh_period;
        logic [2:0]  refresh_wait_states;
        logic        refresh_irq;
        logic [15:0] read_data;
    } result_t;

    // Prescaler divider: 0 (stopped), 2, 8, 32, 128, 512, 2048, 4096
    function automatic logic [12:0] divider(input logic [2:0] code);
        logic [12:0] d;
        case (code)
            3'd1:    d = 13'd2;
            3'd2:    d = 13'd8;
            3'd3:    d = 13'd32;
            3'd4:    d = 13'd128;
            3'd5:    d = 13'd512;
            3'd6:    d = 13'd2048;
            3'd7:    d = 13'd4096;
            default: d = 13'd0;
        endcase
        return d;
    endfunction

    // Same dividers as a shift count, for the period product
    function automatic logic [3:0] divider_shift(input logic [2:0] code);
        logic [3:0] s;
        case (code)
            3'd1:    s = 4'd1;
            3'd2:    s = 4'd3;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd9;
            3'd6:    s = 4'd11;
            3'd7:    s = 4'd12;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

[hdl/bcrt_regfile.sv]
`timescale 1ns / 1ps
// Register file and refresh timer: decodes one word, updates state on fire and
// forms the result from the updated state. Depends on bcrt_pkg.
module bcrt_regfile
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  bcrt_pkg::item_t   item,
    output bcrt_pkg::result_t result
);

    localparam int PERIOD_W_L = bcrt_pkg::PERIOD_W;

    // Stored bits only; fixed bits are filled in on read
    logic [4:0]  bcr_reg,      bcr_next;      // bits 15:11
    logic [7:0]  wcr1_hi_reg,  wcr1_hi_next;  // bits 15:8
    logic        wcr1_b1_reg,  wcr1_b1_next;  // bit 1
    logic [15:0] wcr2_reg,     wcr2_next;
    logic [4:0]  wcr3_reg,     wcr3_next;     // bits 15:11
    logic [7:0]  dcr_reg,      dcr_next;      // bits 15:8
    logic [4:0]  pcr_reg,      pcr_next;      // bits 15:11, flag on top
    logic [3:0]  rtcr_reg,     rtcr_next;     // bits 7:4
    logic [4:0]  rtcsr_reg,    rtcsr_next;    // bits 7:3, flag on top
    logic        mseen_reg,    mseen_next;
    logic        pseen_reg,    pseen_next;
    logic [7:0]  rtcnt_reg,    rtcnt_next;
    logic [7:0]  rtcor_reg,    rtcor_next;
    logic [11:0] psc_reg,      psc_next;

    logic [8:0]  waddr;
    logic [15:0] rd_word;
    logic [15:0] wval;
    logic        in_prot;
    logic        do_write;
    logic [12:0] div_cur;
    logic [12:0] psc_inc;
    logic [7:0]  cnt_inc;
    logic [7:0]  key;
    logic        flag;
    logic [PERIOD_W_L-1:0] period_wide;
    logic [8:0]  cor_plus;

    assign waddr   = {item.address[8:1], 1'b0};
    assign in_prot = (item.address >= bcrt_pkg::ADDR_PROT_LO) &&
                     (item.address <= bcrt_pkg::ADDR_PROT_HI);
    assign key     = wval[15:8];

    // Read view of the addressed word
    always_comb
    begin
        unique case (waddr)
            bcrt_pkg::ADDR_BCR:   rd_word = {bcr_reg, 11'd0};
            bcrt_pkg::ADDR_WCR1:  rd_word = {wcr1_hi_reg, 6'h3f, wcr1_b1_reg, 1'b1};
            bcrt_pkg::ADDR_WCR2:  rd_word = wcr2_reg;
            bcrt_pkg::ADDR_WCR3:  rd_word = {wcr3_reg, 11'd0};
            bcrt_pkg::ADDR_DCR:   rd_word = {dcr_reg, 8'd0};
            bcrt_pkg::ADDR_PCR:   rd_word = {pcr_reg, 11'd0};
            bcrt_pkg::ADDR_RTCR:  rd_word = {8'd0, rtcr_reg, 4'd0};
            bcrt_pkg::ADDR_RTCSR: rd_word = {8'd0, rtcsr_reg, 3'd0};
            bcrt_pkg::ADDR_RTCNT: rd_word = {8'd0, rtcnt_reg};
            bcrt_pkg::ADDR_RTCOR: rd_word = {8'd0, rtcor_reg};
            default:              rd_word = 16'd0;
        endcase
    end

    // Merge a byte into the current word for byte writes
    always_comb
    begin
        if (!item.byte_access)
            wval = item.write_data;
        else if (item.address[0])
            wval = {rd_word[15:8], item.write_data[7:0]};
        else
            wval = {item.write_data[7:0], rd_word[7:0]};
    end

    assign do_write = (item.command == bcrt_pkg::CMD_WRITE) &&
                      (!item.byte_access || !in_prot);
    assign div_cur  = bcrt_pkg::divider(rtcsr_reg[2:0]);
    assign psc_inc  = {1'b0, psc_reg} + 13'd1;
    assign cnt_inc  = rtcnt_reg + 8'd1;

    // Next state for one word
    always_comb
    begin
        bcr_next     = bcr_reg;
        wcr1_hi_next = wcr1_hi_reg;
        wcr1_b1_next = wcr1_b1_reg;
        wcr2_next    = wcr2_reg;
        wcr3_next    = wcr3_reg;
        dcr_next     = dcr_reg;
        pcr_next     = pcr_reg;
        rtcr_next    = rtcr_reg;
        rtcsr_next   = rtcsr_reg;
        mseen_next   = mseen_reg;
        pseen_next   = pseen_reg;
        rtcnt_next   = rtcnt_reg;
        rtcor_next   = rtcor_reg;
        psc_next     = psc_reg;
        flag         = 1'b0;

        case (item.command)
            bcrt_pkg::CMD_TICK:
            begin
                if (div_cur == 13'd0)
                    psc_next = 12'd0;
                else if (psc_inc >= div_cur)
                begin
                    psc_next = 12'd0;
                    if (cnt_inc == rtcor_reg)
                    begin
                        rtcsr_next[4] = 1'b1;
                        rtcnt_next    = 8'd0;
                    end
                    else
                        rtcnt_next = cnt_inc;
                end
                else
                    psc_next = psc_inc[11:0];
            end
            bcrt_pkg::CMD_READ:
            begin
                // Reading a set flag arms its clear
                if (waddr == bcrt_pkg::ADDR_PCR && pcr_reg[4])
                    pseen_next = 1'b1;
                if (waddr == bcrt_pkg::ADDR_RTCSR && rtcsr_reg[4])
                    mseen_next = 1'b1;
            end
            bcrt_pkg::CMD_WRITE:
            begin
                if (do_write)
                begin
                    unique case (waddr)
                        bcrt_pkg::ADDR_BCR:  bcr_next = wval[15:11];
                        bcrt_pkg::ADDR_WCR1:
                        begin
                            wcr1_hi_next = wval[15:8];
                            wcr1_b1_next = wval[1];
                        end
                        bcrt_pkg::ADDR_WCR2: wcr2_next = wval;
                        bcrt_pkg::ADDR_WCR3: wcr3_next = wval[15:11];
                        bcrt_pkg::ADDR_DCR:  dcr_next = wval[15:8];
                        bcrt_pkg::ADDR_PCR:
                        begin
                            // Byte write reads first, which may arm the clear
                            pseen_next = pseen_reg |
                                         (item.byte_access & pcr_reg[4]);
                            flag = pcr_reg[4];
                            if (pseen_next && !wval[15])
                            begin
                                flag       = 1'b0;
                                pseen_next = 1'b0;
                            end
                            else if (wval[15])
                                flag = 1'b1;
                            pcr_next = {flag, wval[14:11]};
                        end
                        bcrt_pkg::ADDR_RTCR:
                        begin
                            if (key == bcrt_pkg::KEY_RTCR)
                                rtcr_next = wval[7:4];
                        end
                        bcrt_pkg::ADDR_RTCSR:
                        begin
                            if (key == bcrt_pkg::KEY_RTCSR)
                            begin
                                flag = rtcsr_reg[4];
                                if (mseen_reg && !wval[7])
                                begin
                                    flag       = 1'b0;
                                    mseen_next = 1'b0;
                                end
                                else if (wval[7])
                                    flag = 1'b1;
                                rtcsr_next = {flag, wval[6:3]};
                                psc_next   = 12'd0;
                            end
                        end
                        bcrt_pkg::ADDR_RTCNT:
                        begin
                            if (key == bcrt_pkg::KEY_RTCNT)
                            begin
                                rtcnt_next = wval[7:0];
                                psc_next   = 12'd0;
                            end
                        end
                        bcrt_pkg::ADDR_RTCOR:
                        begin
                            if (key == bcrt_pkg::KEY_RTCOR)
                                rtcor_next = wval[7:0];
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Result from the updated state
    assign cor_plus    = {1'b0, rtcor_next} + 9'd1;
    assign period_wide = {{(PERIOD_W_L-9){1'b0}}, cor_plus} <<
                         bcrt_pkg::divider_shift(rtcsr_next[2:0]);

    always_comb
    begin
        result.read_data   = (item.command == bcrt_pkg::CMD_READ) ?
                             (item.byte_access ?
                                 (item.address[0] ? {8'd0, rd_word[7:0]} :
                                                    {8'd0, rd_word[15:8]}) :
                                 rd_word) :
                             16'd0;
        result.refresh_irq = rtcsr_next[4] & rtcsr_next[3];
        if (rtcr_next[3] && !rtcr_next[2] && wcr1_hi_next[1])
            result.refresh_wait_states = {1'b0, rtcr_next[1:0]} + 3'd1;
        else
            result.refresh_wait_states = 3'd0;
        if (rtcsr_next[2:0] == 3'd0)
            result.refresh_period = 16'd0;
        else if (period_wide[PERIOD_W_L-1:16] != '0)
            result.refresh_period = 16'hffff;
        else
            result.refresh_period = period_wide[15:0];
    end

    // Commit state when the word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcr_reg     <= 5'd0;
            wcr1_hi_reg <= 8'hff;
            wcr1_b1_reg <= 1'b1;
            wcr2_reg    <= 16'hffff;
            wcr3_reg    <= 5'h1f;
            dcr_reg     <= 8'd0;
            pcr_reg     <= 5'd0;
            rtcr_reg    <= 4'd0;
            rtcsr_reg   <= 5'd0;
            mseen_reg   <= 1'b0;
            pseen_reg   <= 1'b0;
            rtcnt_reg   <= 8'd0;
            rtcor_reg   <= 8'hff;
            psc_reg     <= 12'd0;
        end
        else if (fire)
        begin
            bcr_reg     <= bcr_next;
            wcr1_hi_reg <= wcr1_hi_next;
            wcr1_b1_reg <= wcr1_b1_next;
            wcr2_reg    <= wcr2_next;
            wcr3_reg    <= wcr3_next;
            dcr_reg     <= dcr_next;
            pcr_reg     <= pcr_next;
            rtcr_reg    <= rtcr_next;
            rtcsr_reg   <= rtcsr_next;
            mseen_reg   <= mseen_next;
            pseen_reg   <= pseen_next;
            rtcnt_reg   <= rtcnt_next;
            rtcor_reg   <= rtcor_next;
            psc_reg     <= psc_next;
        end
    end

endmodule

[hdl/bus_controller_refresh_timer_registers.sv]
`timescale 1ns / 1ps
// Top level: input register, register file with refresh timer, result register.
// Depends on bcrt_pkg and bcrt_regfile.
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_axis   in   address[8:0], write_data[24:9], pad to 32   command[1:0], byte_access[2]
//  m_axis   out  read_data[15:0], refresh_irq[16],           -
//                refresh_wait_states[19:17],
//                refresh_period[35:20], pad to 40
//
// One word per cycle while the output is taken, set by the single decode pass
// between the two registers: a word is held in the input register and is applied
// to the register file when it advances, which also loads its result into the
// output register. The input side keeps accepting while the result waits, until
// both registers are full. Reset (rst_n low, asynchronous) clears the registers
// to their documented values and empties both stages.
module bus_controller_refresh_timer_registers
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address, write_data, zero pad
    input  logic [2:0]  s_axis_tuser,   // command, byte_access
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data, refresh_irq, wait states, period, pad
);

    logic              in_valid_reg;
    bcrt_pkg::item_t   item_reg;
    logic              out_valid_reg;
    bcrt_pkg::result_t out_data_reg;
    bcrt_pkg::result_t result;
    logic              advance;

    // Move the held word forward when the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.command     <= s_axis_tuser[1:0];
            item_reg.byte_access <= s_axis_tuser[2];
            item_reg.address     <= s_axis_tdata[8:0];
            item_reg.write_data  <= s_axis_tdata[24:9];
        end
    end

    bcrt_regfile u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (result)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule
